>>> sv/tapaw_pkg.sv
// shared types, constants and saturation helper for the three-axis pid controller
package tapaw_pkg;

	localparam int AXES   = 3;
	localparam int LANE_W = 16;
	localparam int REG_W  = AXES * LANE_W;
	localparam int DIFF_W = LANE_W + 1;
	localparam int TERM_W = 32;
	localparam int WIDE_W = TERM_W + 2;
	localparam int CFG_AW = 2;

	localparam logic [REG_W-1:0] LIMIT_RESET = '1;

	typedef enum logic [CFG_AW-1:0] {
		CFG_PROP  = 2'd0,
		CFG_INTEG = 2'd1,
		CFG_DERIV = 2'd2,
		CFG_LIMIT = 2'd3
	} cfg_idx_t;

	typedef struct packed {
		logic signed [TERM_W-1:0] ctl;
		logic signed [TERM_W-1:0] prop;
		logic signed [TERM_W-1:0] integ;
		logic signed [TERM_W-1:0] deriv;
	} axis_res_t;

	// clip a wide signed value to the 32-bit range
	function automatic logic signed [TERM_W-1:0] sat32(input logic signed [WIDE_W-1:0] v);
		logic [2:0] top;
		top = v[WIDE_W-1:TERM_W-1];
		if (top == 3'b000 || top == 3'b111) begin
			return v[TERM_W-1:0];
		end else if (v[WIDE_W-1]) begin
			return {1'b1, {(TERM_W-1){1'b0}}};
		end else begin
			return {1'b0, {(TERM_W-1){1'b1}}};
		end
	endfunction

endpackage

>>> sv/tapaw_axis.sv
// per-axis pid datapath: products, integral add, clamp and anti-windup rewrite
module tapaw_axis (
	input  logic signed [tapaw_pkg::DIFF_W-1:0] err,
	input  logic signed [tapaw_pkg::DIFF_W-1:0] dlt,
	input  logic signed [tapaw_pkg::LANE_W-1:0] kp,
	input  logic signed [tapaw_pkg::LANE_W-1:0] ki,
	input  logic signed [tapaw_pkg::LANE_W-1:0] kd,
	input  logic signed [tapaw_pkg::LANE_W-1:0] lim,
	input  logic signed [tapaw_pkg::TERM_W-1:0] acc,
	output tapaw_pkg::axis_res_t                res
);
	localparam int PW = tapaw_pkg::DIFF_W + tapaw_pkg::LANE_W;
	localparam int WW = tapaw_pkg::WIDE_W;
	localparam int TW = tapaw_pkg::TERM_W;

	logic signed [PW-1:0] p_full, i_full, d_full;
	logic signed [TW-1:0] p, ik, d, i_acc, ctl_raw, ctl, lim_pos, lim_neg;
	logic signed [WW-1:0] pd_sum, i_sum, raw_sum, aw_diff;

	assign p_full = PW'(err) * PW'(kp);
	assign i_full = PW'(err) * PW'(ki);
	assign d_full = PW'(dlt) * PW'(kd);

	assign p  = tapaw_pkg::sat32(WW'(p_full));
	assign ik = tapaw_pkg::sat32(WW'(i_full));
	assign d  = tapaw_pkg::sat32(WW'(d_full));

	assign i_sum   = WW'(acc) + WW'(ik);
	assign i_acc   = tapaw_pkg::sat32(i_sum);
	assign pd_sum  = WW'(p) + WW'(d);
	assign raw_sum = pd_sum + WW'(i_acc);
	assign ctl_raw = tapaw_pkg::sat32(raw_sum);

	// limit is q8.8, clamp bound is q16.16
	assign lim_pos = TW'({1'b0, lim[tapaw_pkg::LANE_W-2:0], 8'b0});
	assign lim_neg = -lim_pos;

	always_comb begin
		ctl = ctl_raw;
		if (!lim[tapaw_pkg::LANE_W-1]) begin
			if (ctl_raw > lim_pos) begin
				ctl = lim_pos;
			end else if (ctl_raw < lim_neg) begin
				ctl = lim_neg;
			end
		end
	end

	// back-calculation: when ki is nonzero, the integral becomes what the clamp left over
	assign aw_diff = WW'(ctl) - pd_sum;

	always_comb begin
		res.ctl   = ctl;
		res.prop  = p;
		res.deriv = d;
		res.integ = (ki != '0) ? tapaw_pkg::sat32(aw_diff) : i_acc;
	end

endmodule

>>> sv/three_axis_pid_antiwindup_top.sv
// three-axis pid controller with clamping and back-calculation anti-windup
// an accepted beat is held in the input register, then moves on to the result register
// throughput: one beat per cycle while the output is not stalled; the per-axis integral is
// read and updated in the single stage between the input and result registers
// reset: gains clear, limits go to all ones (no clamp), integrals and last measurements clear
module three_axis_pid_antiwindup_top (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [tapaw_pkg::CFG_AW-1:0]        cfg_addr,
	input  logic [tapaw_pkg::REG_W-1:0]         cfg_wdata,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic signed [tapaw_pkg::LANE_W-1:0] setpoint_x,
	input  logic signed [tapaw_pkg::LANE_W-1:0] setpoint_y,
	input  logic signed [tapaw_pkg::LANE_W-1:0] setpoint_z,
	input  logic signed [tapaw_pkg::LANE_W-1:0] measured_x,
	input  logic signed [tapaw_pkg::LANE_W-1:0] measured_y,
	input  logic signed [tapaw_pkg::LANE_W-1:0] measured_z,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic signed [tapaw_pkg::TERM_W-1:0] control_x,
	output logic signed [tapaw_pkg::TERM_W-1:0] control_y,
	output logic signed [tapaw_pkg::TERM_W-1:0] control_z,
	output logic signed [tapaw_pkg::TERM_W-1:0] prop_term_x,
	output logic signed [tapaw_pkg::TERM_W-1:0] prop_term_y,
	output logic signed [tapaw_pkg::TERM_W-1:0] prop_term_z,
	output logic signed [tapaw_pkg::TERM_W-1:0] integ_term_x,
	output logic signed [tapaw_pkg::TERM_W-1:0] integ_term_y,
	output logic signed [tapaw_pkg::TERM_W-1:0] integ_term_z,
	output logic signed [tapaw_pkg::TERM_W-1:0] deriv_term_x,
	output logic signed [tapaw_pkg::TERM_W-1:0] deriv_term_y,
	output logic signed [tapaw_pkg::TERM_W-1:0] deriv_term_z
);
	localparam int AX = tapaw_pkg::AXES;
	localparam int LW = tapaw_pkg::LANE_W;
	localparam int DW = tapaw_pkg::DIFF_W;
	localparam int TW = tapaw_pkg::TERM_W;

	logic [tapaw_pkg::REG_W-1:0] prop_q, integ_q, deriv_q, limit_q;

	logic signed [LW-1:0] sp [AX];
	logic signed [LW-1:0] ms [AX];
	logic signed [LW-1:0] prev_q [AX];
	logic signed [TW-1:0] acc_q [AX];
	logic signed [DW-1:0] err_s1 [AX];
	logic signed [DW-1:0] dlt_s1 [AX];
	logic                 s1_valid_q;
	logic                 out_valid_q;
	logic                 advance;
	logic                 in_fire;

	tapaw_pkg::axis_res_t res [AX];
	tapaw_pkg::axis_res_t res_q [AX];

	assign sp[0] = setpoint_x;
	assign sp[1] = setpoint_y;
	assign sp[2] = setpoint_z;
	assign ms[0] = measured_x;
	assign ms[1] = measured_y;
	assign ms[2] = measured_z;

	// the result register frees up when empty or being drained this cycle
	assign advance  = s1_valid_q && (!out_valid_q || out_ready);
	assign in_ready = !s1_valid_q || advance;
	assign in_fire  = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prop_q  <= '0;
			integ_q <= '0;
			deriv_q <= '0;
			limit_q <= tapaw_pkg::LIMIT_RESET;
		end else if (cfg_we) begin
			case (cfg_addr)
				tapaw_pkg::CFG_PROP:  prop_q  <= cfg_wdata;
				tapaw_pkg::CFG_INTEG: integ_q <= cfg_wdata;
				tapaw_pkg::CFG_DERIV: deriv_q <= cfg_wdata;
				tapaw_pkg::CFG_LIMIT: limit_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (in_fire) begin
				s1_valid_q <= 1'b1;
			end else if (advance) begin
				s1_valid_q <= 1'b0;
			end
			if (advance) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	for (genvar a = 0; a < AX; a++) begin : g_axis
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				prev_q[a] <= '0;
				acc_q[a]  <= '0;
			end else begin
				if (in_fire) begin
					prev_q[a] <= ms[a];
				end
				if (advance) begin
					acc_q[a] <= res[a].integ;
				end
			end
		end

		// differences are exact 17-bit values, taken at the input edge
		always_ff @(posedge clk) begin
			if (in_fire) begin
				err_s1[a] <= DW'(sp[a]) - DW'(ms[a]);
				dlt_s1[a] <= DW'(prev_q[a]) - DW'(ms[a]);
			end
			if (advance) begin
				res_q[a] <= res[a];
			end
		end

		tapaw_axis u_axis (
			.err (err_s1[a]),
			.dlt (dlt_s1[a]),
			.kp  (prop_q[LW*a +: LW]),
			.ki  (integ_q[LW*a +: LW]),
			.kd  (deriv_q[LW*a +: LW]),
			.lim (limit_q[LW*a +: LW]),
			.acc (acc_q[a]),
			.res (res[a])
		);
	end

	assign out_valid    = out_valid_q;
	assign control_x    = res_q[0].ctl;
	assign control_y    = res_q[1].ctl;
	assign control_z    = res_q[2].ctl;
	assign prop_term_x  = res_q[0].prop;
	assign prop_term_y  = res_q[1].prop;
	assign prop_term_z  = res_q[2].prop;
	assign integ_term_x = res_q[0].integ;
	assign integ_term_y = res_q[1].integ;
	assign integ_term_z = res_q[2].integ;
	assign deriv_term_x = res_q[0].deriv;
	assign deriv_term_y = res_q[1].deriv;
	assign deriv_term_z = res_q[2].deriv;

	// integrals only move when a beat leaves the stage
	a_acc_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !out_ready) |=> ($stable(acc_q[0]) && $stable(acc_q[1]) && $stable(acc_q[2])))
		else $error("integral changed while the result register was stalled");

	a_ready_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!s1_valid_q |-> in_ready)
		else $error("input not ready with an empty stage");

	a_fire_fills: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire |=> s1_valid_q)
		else $error("accepted beat did not reach the stage");

	a_prev_track: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire |=> (prev_q[0] == $past(measured_x) && prev_q[2] == $past(measured_z)))
		else $error("last measurement not captured on accept");

endmodule

>>> bench/three_axis_pid_antiwindup_top_test.sv
// self-checking bench for the three-axis pid controller: predicted beats vs dut results
`timescale 1ns / 100ps

module three_axis_pid_antiwindup_top_test;
	localparam int AX = tapaw_pkg::AXES;
	localparam int LW = tapaw_pkg::LANE_W;
	localparam int TW = tapaw_pkg::TERM_W;
	localparam int RW = tapaw_pkg::REG_W;

	typedef tapaw_pkg::axis_res_t [AX-1:0] pid_result_t;

	class pid_scoreboard;
		logic [RW-1:0] kp_reg, ki_reg, kd_reg, lim_reg;
		logic signed [TW-1:0] integ_acc [AX];
		logic signed [LW-1:0] last_meas [AX];
		pid_result_t pending_q [$];
		int errors;

		function new();
			kp_reg = '0;
			ki_reg = '0;
			kd_reg = '0;
			lim_reg = tapaw_pkg::LIMIT_RESET;
			errors = 0;
			for (int a = 0; a < AX; a++) begin
				integ_acc[a] = '0;
				last_meas[a] = '0;
			end
		endfunction

		function longint lane_of(logic [RW-1:0] r, int a);
			logic signed [LW-1:0] s;
			s = r[a*LW +: LW];
			return s;
		endfunction

		function logic signed [TW-1:0] clip32(longint v);
			if (v > 64'sd2147483647) return 32'sh7fffffff;
			if (v < -64'sd2147483648) return 32'sh80000000;
			return v[TW-1:0];
		endfunction

		function void set_reg(tapaw_pkg::cfg_idx_t idx, logic [RW-1:0] val);
			case (idx)
				tapaw_pkg::CFG_PROP:  kp_reg = val;
				tapaw_pkg::CFG_INTEG: ki_reg = val;
				tapaw_pkg::CFG_DERIV: kd_reg = val;
				tapaw_pkg::CFG_LIMIT: lim_reg = val;
				default: ;
			endcase
		endfunction

		// one accepted sample: step every axis and queue the predicted beat
		function void note_sample(logic [RW-1:0] sp_w, logic [RW-1:0] ms_w);
			longint sp, ms, kp, ki, kd, lim, err, dlt, clamp;
			logic signed [TW-1:0] p, i, d, ctl;
			pid_result_t want;
			for (int a = 0; a < AX; a++) begin
				sp = lane_of(sp_w, a);
				ms = lane_of(ms_w, a);
				kp = lane_of(kp_reg, a);
				ki = lane_of(ki_reg, a);
				kd = lane_of(kd_reg, a);
				lim = lane_of(lim_reg, a);
				err = sp - ms;
				dlt = longint'(last_meas[a]) - ms;
				p = clip32(err * kp);
				d = clip32(dlt * kd);
				i = clip32(longint'(integ_acc[a]) + longint'(clip32(err * ki)));
				ctl = clip32(longint'(p) + longint'(i) + longint'(d));
				// negative limit lane leaves the output unclamped
				if (lim >= 0) begin
					clamp = lim * 256;
					if (longint'(ctl) > clamp) ctl = clamp[TW-1:0];
					if (longint'(ctl) < -clamp) ctl = clamp_neg(clamp);
				end
				// back-calculation only when the integral gain is active
				if (ki != 0) i = clip32(longint'(ctl) - (longint'(p) + longint'(d)));
				integ_acc[a] = i;
				last_meas[a] = ms[LW-1:0];
				want[a] = {ctl, p, i, d};
			end
			pending_q.push_back(want);
		endfunction

		function logic signed [TW-1:0] clamp_neg(longint c);
			longint n;
			n = -c;
			return n[TW-1:0];
		endfunction

		function void check_result(pid_result_t got);
			string field_name [4];
			string axis_name [AX];
			pid_result_t want;
			logic [4*TW-1:0] w, g;
			field_name = '{"control", "prop_term", "integ_term", "deriv_term"};
			axis_name = '{"x", "y", "z"};
			if (pending_q.size() == 0) begin
				$display("%0t: result beat with nothing predicted, control_x %h", $time,
					got[0].ctl);
				errors++;
				return;
			end
			want = pending_q.pop_front();
			for (int a = 0; a < AX; a++) begin
				w = want[a];
				g = got[a];
				for (int f = 0; f < 4; f++) begin
					if (w[4*TW-1-TW*f -: TW] !== g[4*TW-1-TW*f -: TW]) begin
						$display("%0t: %s_%s expected %h actual %h", $time, field_name[f],
							axis_name[a], w[4*TW-1-TW*f -: TW],
							g[4*TW-1-TW*f -: TW]);
						errors++;
					end
				end
			end
		endfunction

		function int pending();
			return pending_q.size();
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [tapaw_pkg::CFG_AW-1:0] cfg_addr = '0;
	logic [RW-1:0] cfg_wdata = '0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic signed [LW-1:0] setpoint_x = '0, setpoint_y = '0, setpoint_z = '0;
	logic signed [LW-1:0] measured_x = '0, measured_y = '0, measured_z = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic signed [TW-1:0] control_x, control_y, control_z;
	logic signed [TW-1:0] prop_term_x, prop_term_y, prop_term_z;
	logic signed [TW-1:0] integ_term_x, integ_term_y, integ_term_z;
	logic signed [TW-1:0] deriv_term_x, deriv_term_y, deriv_term_z;

	pid_scoreboard sb = new();
	int send_calm = 0;
	int recv_calm = 0;

	three_axis_pid_antiwindup_top i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_addr(cfg_addr),
		.cfg_wdata(cfg_wdata),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.setpoint_x(setpoint_x),
		.setpoint_y(setpoint_y),
		.setpoint_z(setpoint_z),
		.measured_x(measured_x),
		.measured_y(measured_y),
		.measured_z(measured_z),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.control_x(control_x),
		.control_y(control_y),
		.control_z(control_z),
		.prop_term_x(prop_term_x),
		.prop_term_y(prop_term_y),
		.prop_term_z(prop_term_z),
		.integ_term_x(integ_term_x),
		.integ_term_y(integ_term_y),
		.integ_term_z(integ_term_z),
		.deriv_term_x(deriv_term_x),
		.deriv_term_y(deriv_term_y),
		.deriv_term_z(deriv_term_z)
	);

	always #10 clk = ~clk;

	// idle cycles before a beat, with occasional runs of back-to-back beats
	function automatic int draw_gap(inout int calm);
		if (calm > 0) begin
			calm--;
			return 0;
		end
		if ($urandom_range(0, 15) == 0) calm = $urandom_range(20, 60);
		return $urandom_range(0, 7);
	endfunction

	function automatic logic [LW-1:0] rand_lane();
		case ($urandom_range(0, 7))
			0: return 16'h7fff;
			1: return 16'h8000;
			2: return 16'h0000;
			3: return 16'hffff;
			4: return 16'h0100;
			5: return 16'($urandom_range(0, 1023)) - 16'd512;
			default: return 16'($urandom);
		endcase
	endfunction

	function automatic logic [RW-1:0] rand_reg();
		return {rand_lane(), rand_lane(), rand_lane()};
	endfunction

	function automatic pid_result_t pack_result();
		pid_result_t r;
		r[0] = {control_x, prop_term_x, integ_term_x, deriv_term_x};
		r[1] = {control_y, prop_term_y, integ_term_y, deriv_term_y};
		r[2] = {control_z, prop_term_z, integ_term_z, deriv_term_z};
		return r;
	endfunction

	task automatic write_reg(input tapaw_pkg::cfg_idx_t idx, input logic [RW-1:0] val);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_addr <= idx;
		cfg_wdata <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
		sb.set_reg(idx, val);
	endtask

	task automatic write_all(input logic [RW-1:0] kp, input logic [RW-1:0] ki,
		input logic [RW-1:0] kd, input logic [RW-1:0] lim);
		write_reg(tapaw_pkg::CFG_PROP, kp);
		write_reg(tapaw_pkg::CFG_INTEG, ki);
		write_reg(tapaw_pkg::CFG_DERIV, kd);
		write_reg(tapaw_pkg::CFG_LIMIT, lim);
	endtask

	task automatic send_sample(input logic [RW-1:0] sp, input logic [RW-1:0] ms);
		int gap;
		gap = draw_gap(send_calm);
		@(negedge clk);
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		setpoint_x <= sp[15:0];
		setpoint_y <= sp[31:16];
		setpoint_z <= sp[47:32];
		measured_x <= ms[15:0];
		measured_y <= ms[31:16];
		measured_z <= ms[47:32];
		in_valid <= 1'b1;
		do @(posedge clk); while (!in_ready);
		sb.note_sample(sp, ms);
	endtask

	// hold new beats back until every predicted result has come out
	task automatic drain();
		@(negedge clk);
		in_valid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	initial begin
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		forever begin
			int gap;
			gap = draw_gap(recv_calm);
			@(negedge clk);
			if (gap != 0) begin
				out_ready <= 1'b0;
				repeat (gap) @(negedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!out_valid);
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			sb.check_result(pack_result());
		end
	end

	initial begin
		#8_000_000;
		$display("three_axis_pid_antiwindup_top_test: errors");
		$finish;
	end

	initial begin
		@(posedge arst_n);
		// x: zero limit, y: integral gain off, z: unclamped
		write_all({16'h8000, 16'h7fff, 16'h0100}, {16'h7fff, 16'h0000, 16'h0100},
			{16'h0100, 16'h7fff, 16'h8000}, {16'hffff, 16'h7fff, 16'h0000});
		// first beat sees a zero previous measurement
		send_sample({3{16'h0100}}, {3{16'h8000}});
		send_sample({3{16'h0000}}, {3{16'h0000}});
		send_sample({3{16'h7fff}}, {3{16'h8000}});
		send_sample({3{16'h8000}}, {3{16'h7fff}});
		send_sample({3{16'h7fff}}, {3{16'h7fff}});
		send_sample({3{16'h8000}}, {3{16'h8000}});
		send_sample({3{16'h0000}}, {3{16'h7fff}});
		send_sample({3{16'h0001}}, {3{16'h0000}});
		send_sample({3{16'hffff}}, {3{16'h0001}});
		// push the integral into saturation both ways
		repeat (4) send_sample({3{16'h7fff}}, {3{16'h8000}});
		repeat (4) send_sample({3{16'h8000}}, {3{16'h7fff}});
		drain();
		write_all({16'h0100, 16'hffff, 16'h0080}, {16'h0000, 16'h8000, 16'h0040},
			{16'h0040, 16'h0000, 16'hffff}, {16'h0200, 16'h0010, 16'h8000});
		send_sample({16'h0400, 16'h8000, 16'h7fff}, {16'h0000, 16'h7fff, 16'h8000});
		send_sample({16'hfc00, 16'h7fff, 16'h8000}, {16'h0100, 16'h8000, 16'h7fff});
		send_sample({16'h1234, 16'hedcb, 16'h0050}, {16'h0050, 16'h1234, 16'hedcb});
		send_sample({3{16'h7fff}}, {3{16'h0000}});
		send_sample({3{16'h8000}}, {3{16'h0000}});
		send_sample({3{16'h0000}}, {3{16'hffff}});
		drain();

		for (int ph = 0; ph < 10; ph++) begin
			case (ph)
				0: write_all({3{16'h7fff}}, {3{16'h7fff}}, {3{16'h7fff}}, {3{16'h7fff}});
				1: write_all({3{16'h8000}}, {3{16'h8000}}, {3{16'h8000}}, {3{16'h0000}});
				2: write_all({3{16'h0000}}, {3{16'h0000}}, {3{16'h0000}}, {3{16'hffff}});
				default: write_all(rand_reg(), rand_reg(), rand_reg(), rand_reg());
			endcase
			for (int n = 0; n < 173; n++) begin
				send_sample(rand_reg(), rand_reg());
				if (ph == 5 && n == 80) drain();
			end
			drain();
		end

		while (sb.pending() != 0) @(posedge clk);
		repeat (10) @(posedge clk);
		if (sb.errors == 0) begin
			$display("three_axis_pid_antiwindup_top_test: clean");
		end else begin
			$display("three_axis_pid_antiwindup_top_test: errors");
		end
		$finish;
	end

endmodule
